// ----- rtl/sqc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the sprite quad corner block.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package sqc_pkg;

    // Width of the exact Q32 corner sums.
    localparam int SUM_W = 60;

    // Angle units: 1/64 degree.
    localparam logic [14:0] QUARTER_UNITS = 15'd5760;
    localparam logic [14:0] HALF_UNITS    = 15'd11520;
    localparam logic [14:0] THREEQ_UNITS  = 15'd17280;
    localparam logic [14:0] FULL_UNITS    = 15'd23040;

    // Radians per angle unit in Q30, and one in Q30.
    localparam logic [18:0] RAD_PER_UNIT_Q30 = 19'd292818;
    localparam logic [31:0] Q30_ONE          = 32'h4000_0000;

    // Reciprocals for exact truncating division of 32-bit values by constants.
    localparam int unsigned DIV72_SH = 39;
    localparam int unsigned DIV42_SH = 38;
    localparam int unsigned DIV20_SH = 37;
    localparam int unsigned DIV6_SH  = 35;
    localparam logic [32:0] DIV72_M = 33'(((65'd1 << DIV72_SH) + 65'd71) / 65'd72);
    localparam logic [32:0] DIV42_M = 33'(((65'd1 << DIV42_SH) + 65'd41) / 65'd42);
    localparam logic [32:0] DIV20_M = 33'(((65'd1 << DIV20_SH) + 65'd19) / 65'd20);
    localparam logic [32:0] DIV6_M  = 33'(((65'd1 << DIV6_SH) + 65'd5) / 65'd6);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] angle;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
    } sqc_in_t;

    typedef struct packed {
        logic [1:0]         corner_index;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic               last_corner;
    } sqc_out_t;

    // Four corners of one sprite, unrounded, at Q32.
    typedef struct packed {
        logic signed [SUM_W-1:0] x0;
        logic signed [SUM_W-1:0] x1;
        logic signed [SUM_W-1:0] x2;
        logic signed [SUM_W-1:0] x3;
        logic signed [SUM_W-1:0] y0;
        logic signed [SUM_W-1:0] y1;
        logic signed [SUM_W-1:0] y2;
        logic signed [SUM_W-1:0] y3;
    } sqc_quad_t;

    // Truncating division by a constant as a multiply by its reciprocal.
    function automatic logic [31:0] div_const(input logic [31:0] v, input logic [32:0] m,
                                              input int unsigned sh);
        logic [64:0] prod;
        prod = 65'(v) * 65'(m);
        return 32'(prod >> sh);
    endfunction

    // One Horner step: (x2 * (1 - d)) >> 30.
    function automatic logic [31:0] horner_step(input logic [31:0] x2, input logic [31:0] d);
        logic [30:0] t;
        logic [62:0] prod;
        t    = 31'(Q30_ONE) - d[30:0];
        prod = 63'(x2) * 63'(t);
        return 32'(prod >> 30);
    endfunction

    // Round a Q32 value to Q16.16 and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + SUM_W'(32768)) >>> 16;
        if (r > SUM_W'(32'sh7fff_ffff)) begin
            return 32'sh7fff_ffff;
        end else if (r < SUM_W'(32'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

endpackage

// ----- rtl/sqc_sine.sv -----
// Ten-stage pipelined quarter-wave sine: Q2.30 Taylor series in Horner form, Q16 result.
// Depends on sqc_pkg for constants and the divide and Horner helpers.
`timescale 1ns / 1ps

module sqc_sine (
    input  logic               aclk,
    input  logic               en,
    input  logic [12:0]        u,
    input  logic               neg,
    output logic signed [17:0] sin_q16
);

    logic [30:0]        x_reg   [1:9];
    logic [31:0]        x2_reg  [2:7];
    logic [31:0]        acc_reg [3:9];
    logic               neg_reg [1:9];
    logic signed [17:0] sin_reg;

    logic [61:0]        sq_full;
    logic [61:0]        fin_full;
    logic [30:0]        t_last;
    logic [31:0]        s_raw;
    logic [31:0]        s_clamp;
    logic [16:0]        s_rnd;
    logic signed [17:0] s_mag;

    // Square of the angle in radians, and the final multiply with clamp and rounding.
    always_comb begin
        sq_full  = 62'(x_reg[1]) * 62'(x_reg[1]);
        t_last   = 31'(sqc_pkg::Q30_ONE) - acc_reg[9][30:0];
        fin_full = 62'(x_reg[9]) * 62'(t_last);
        s_raw    = 32'(fin_full >> 30);
        s_clamp  = (s_raw > sqc_pkg::Q30_ONE) ? sqc_pkg::Q30_ONE : s_raw;
        s_rnd    = 17'((s_clamp + 32'd8192) >> 14);
        s_mag    = $signed({1'b0, s_rnd});
    end

    // Series stages alternate between a constant divide and a Horner multiply.
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[1]   <= 31'(u) * 31'(sqc_pkg::RAD_PER_UNIT_Q30);
            neg_reg[1] <= neg;
            for (int k = 2; k <= 9; k++) begin
                x_reg[k]   <= x_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            x2_reg[2] <= 32'(sq_full >> 30);
            for (int k = 3; k <= 7; k++) begin
                x2_reg[k] <= x2_reg[k-1];
            end
            acc_reg[3] <= sqc_pkg::div_const(x2_reg[2], sqc_pkg::DIV72_M, sqc_pkg::DIV72_SH);
            acc_reg[4] <= sqc_pkg::horner_step(x2_reg[3], acc_reg[3]);
            acc_reg[5] <= sqc_pkg::div_const(acc_reg[4], sqc_pkg::DIV42_M, sqc_pkg::DIV42_SH);
            acc_reg[6] <= sqc_pkg::horner_step(x2_reg[5], acc_reg[5]);
            acc_reg[7] <= sqc_pkg::div_const(acc_reg[6], sqc_pkg::DIV20_M, sqc_pkg::DIV20_SH);
            acc_reg[8] <= sqc_pkg::horner_step(x2_reg[7], acc_reg[7]);
            acc_reg[9] <= sqc_pkg::div_const(acc_reg[8], sqc_pkg::DIV6_M, sqc_pkg::DIV6_SH);
            sin_reg    <= neg_reg[9] ? -s_mag : s_mag;
        end
    end

    assign sin_q16 = sin_reg;

endmodule

// ----- rtl/sqc_front.sv -----
// Front end: accepts sprites, reduces the angle, runs sine and cosine, forms corner sums.
// Depends on sqc_pkg and sqc_sine; 13-stage pipeline that stalls as a whole.
`timescale 1ns / 1ps

module sqc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sqc_pkg::sqc_in_t   s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output sqc_pkg::sqc_quad_t q_data
);

    localparam int W = sqc_pkg::SUM_W;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [39:0] rx;
        logic signed [39:0] ry;
        logic               zero;
    } side_t;

    typedef struct packed {
        logic signed [W-1:0] cvx;
        logic signed [W-1:0] svy;
        logic signed [W-1:0] svx;
        logic signed [W-1:0] cvy;
        logic signed [W-1:0] crx;
        logic signed [W-1:0] srx;
        logic signed [W-1:0] sry;
        logic signed [W-1:0] cry;
        logic signed [31:0]  px;
        logic signed [31:0]  py;
        logic signed [39:0]  rx;
        logic signed [39:0]  ry;
        logic                zero;
    } prod_t;

    typedef struct packed {
        logic signed [W-1:0] ox;
        logic signed [W-1:0] oy;
        logic signed [W-1:0] xx;
        logic signed [W-1:0] xy;
        logic signed [W-1:0] yx;
        logic signed [W-1:0] yy;
    } vec_t;

    logic [13:1]        v_reg;
    side_t              side_reg [1:10];
    prod_t              prod_reg;
    vec_t               vec_reg;
    sqc_pkg::sqc_quad_t quad_reg;

    logic               en;
    logic signed [17:0] a_ext;
    logic [14:0]        r_sin;
    logic [15:0]        r_plus;
    logic [14:0]        r_cos;
    logic [12:0]        u_sin, u_cos;
    logic               n_sin, n_cos;
    logic signed [17:0] sin_v, cos_v;
    logic signed [47:0] raw_x, raw_y;
    side_t              side_in;
    vec_t               vec_next;

    // Fold an angle in [0, 360) degrees onto the first quadrant, with sign.
    function automatic logic [13:0] fold(input logic [14:0] r);
        priority if (r < sqc_pkg::QUARTER_UNITS) begin
            return {1'b0, 13'(r)};
        end else if (r < sqc_pkg::HALF_UNITS) begin
            return {1'b0, 13'(sqc_pkg::HALF_UNITS - r)};
        end else if (r < sqc_pkg::THREEQ_UNITS) begin
            return {1'b1, 13'(r - sqc_pkg::HALF_UNITS)};
        end else begin
            return {1'b1, 13'(sqc_pkg::FULL_UNITS - r)};
        end
    endfunction

    // The whole pipeline holds while a finished sprite waits on a full queue.
    assign en      = !(v_reg[13] && !q_ready);
    assign s_ready = en;
    assign q_valid = v_reg[13];
    assign q_data  = quad_reg;

    // Angle reduction modulo 360 degrees, and the cosine angle a quarter turn on.
    always_comb begin
        a_ext = 18'(s_data.angle);
        priority if (a_ext < -18'sd23040) begin
            r_sin = 15'(a_ext + 18'sd46080);
        end else if (a_ext < 18'sd0) begin
            r_sin = 15'(a_ext + 18'sd23040);
        end else if (a_ext >= 18'sd23040) begin
            r_sin = 15'(a_ext - 18'sd23040);
        end else begin
            r_sin = 15'(a_ext);
        end
        r_plus = 16'(r_sin) + 16'(sqc_pkg::QUARTER_UNITS);
        r_cos  = (r_plus >= 16'(sqc_pkg::FULL_UNITS)) ?
                 15'(r_plus - 16'(sqc_pkg::FULL_UNITS)) : 15'(r_plus);
        {n_sin, u_sin} = fold(r_sin);
        {n_cos, u_cos} = fold(r_cos);
    end

    // Scaled size, rounded from Q24.24 to Q24.16.
    always_comb begin
        raw_x        = 48'(s_data.size_x) * 48'(s_data.scale_x);
        raw_y        = 48'(s_data.size_y) * 48'(s_data.scale_y);
        side_in.px   = s_data.pos_x;
        side_in.py   = s_data.pos_y;
        side_in.vx   = s_data.pivot_x;
        side_in.vy   = s_data.pivot_y;
        side_in.rx   = 40'((raw_x + 48'sd128) >>> 8);
        side_in.ry   = 40'((raw_y + 48'sd128) >>> 8);
        side_in.zero = (s_data.angle == 16'sd0);
    end

    sqc_sine u_sin_lane (
        .aclk    (aclk),
        .en      (en),
        .u       (u_sin),
        .neg     (n_sin),
        .sin_q16 (sin_v)
    );

    sqc_sine u_cos_lane (
        .aclk    (aclk),
        .en      (en),
        .u       (u_cos),
        .neg     (n_cos),
        .sin_q16 (cos_v)
    );

    // Origin and edge vectors; a zero angle gives an axis-aligned box.
    always_comb begin
        if (prod_reg.zero) begin
            vec_next.ox = W'(prod_reg.px) <<< 16;
            vec_next.oy = W'(prod_reg.py) <<< 16;
            vec_next.xx = W'(prod_reg.rx) <<< 16;
            vec_next.xy = '0;
            vec_next.yx = '0;
            vec_next.yy = W'(prod_reg.ry) <<< 16;
        end else begin
            vec_next.ox = (W'(prod_reg.px) <<< 16) - prod_reg.cvx - prod_reg.svy;
            vec_next.oy = (W'(prod_reg.py) <<< 16) + prod_reg.svx - prod_reg.cvy;
            vec_next.xx = prod_reg.crx;
            vec_next.xy = -prod_reg.srx;
            vec_next.yx = prod_reg.sry;
            vec_next.yy = prod_reg.cry;
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[12:1], s_valid};
        end
    end

    // Data stages: side data beside the sine lanes, then products, vectors and sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= side_in;
            for (int k = 2; k <= 10; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            prod_reg.cvx  <= W'(cos_v) * W'(side_reg[10].vx);
            prod_reg.svy  <= W'(sin_v) * W'(side_reg[10].vy);
            prod_reg.svx  <= W'(sin_v) * W'(side_reg[10].vx);
            prod_reg.cvy  <= W'(cos_v) * W'(side_reg[10].vy);
            prod_reg.crx  <= W'(cos_v) * W'(side_reg[10].rx);
            prod_reg.srx  <= W'(sin_v) * W'(side_reg[10].rx);
            prod_reg.sry  <= W'(sin_v) * W'(side_reg[10].ry);
            prod_reg.cry  <= W'(cos_v) * W'(side_reg[10].ry);
            prod_reg.px   <= side_reg[10].px;
            prod_reg.py   <= side_reg[10].py;
            prod_reg.rx   <= side_reg[10].rx;
            prod_reg.ry   <= side_reg[10].ry;
            prod_reg.zero <= side_reg[10].zero;
            vec_reg       <= vec_next;
            quad_reg.x0   <= vec_reg.ox;
            quad_reg.x1   <= vec_reg.ox + vec_reg.xx;
            quad_reg.x2   <= vec_reg.ox + vec_reg.xx + vec_reg.yx;
            quad_reg.x3   <= vec_reg.ox + vec_reg.yx;
            quad_reg.y0   <= vec_reg.oy;
            quad_reg.y1   <= vec_reg.oy + vec_reg.xy;
            quad_reg.y2   <= vec_reg.oy + vec_reg.xy + vec_reg.yy;
            quad_reg.y3   <= vec_reg.oy + vec_reg.yy;
        end
    end

endmodule

// ----- rtl/sqc_queue.sv -----
// Two-entry queue between the front end and the corner sequencer.
// Depends on sqc_pkg for the corner set type.
`timescale 1ns / 1ps

module sqc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  sqc_pkg::sqc_quad_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output sqc_pkg::sqc_quad_t pop_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    sqc_pkg::sqc_quad_t mem_reg [0:1];
    logic [1:0]         count_reg, count_next;
    logic               wr_ptr_reg, rd_ptr_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != DEPTH);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy count.
    always_comb begin
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/sqc_back.sv -----
// Back end: sends each queued sprite's four corners, a word per unstalled cycle.
// Depends on sqc_pkg for types and the round and saturate helper.
`timescale 1ns / 1ps

module sqc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  sqc_pkg::sqc_quad_t q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sqc_pkg::sqc_out_t  m_data
);

    logic [1:0]                    corner_reg;
    logic                          m_valid_reg, m_valid_next;
    sqc_pkg::sqc_out_t             out_reg;
    logic                          load;
    logic signed [sqc_pkg::SUM_W-1:0] sel_x, sel_y;

    // A new word loads when the output register is empty or being taken.
    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign q_ready = load && (corner_reg == 2'd3);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Pick the current corner.
    always_comb begin
        unique case (corner_reg)
            2'd0: begin
                sel_x = q_data.x0;
                sel_y = q_data.y0;
            end
            2'd1: begin
                sel_x = q_data.x1;
                sel_y = q_data.y1;
            end
            2'd2: begin
                sel_x = q_data.x2;
                sel_y = q_data.y2;
            end
            default: begin
                sel_x = q_data.x3;
                sel_y = q_data.y3;
            end
        endcase
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // Corner counter and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (load) begin
                corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg.corner_index <= corner_reg;
            out_reg.corner_x     <= sqc_pkg::round_sat(sel_x);
            out_reg.corner_y     <= sqc_pkg::round_sat(sel_y);
            out_reg.last_corner  <= (corner_reg == 2'd3);
        end
    end

endmodule

// ----- rtl/sprite_quad_corners.sv -----
// Top level of the rotated, scaled sprite quad corner generator.
// Depends on sqc_pkg, sqc_front, sqc_queue and sqc_back.
//
//   Channel  Ports                        Word
//   input    s_valid, s_ready, s_data     one sprite (sqc_in_t)
//   output   m_valid, m_ready, m_data     one corner (sqc_out_t)
//
// A taken sprite passes through the front pipeline, the queue and the output
// register before its first corner leaves. Throughput is set by the single
// output port that sends the four corners of each sprite in turn.
// Reset is synchronous and active low and empties every stage and the queue.
// A stalled output fills the two-entry queue, then holds the front pipeline.
`timescale 1ns / 1ps

module sprite_quad_corners (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sqc_pkg::sqc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sqc_pkg::sqc_out_t m_data
);

    logic               f_valid, f_ready;
    sqc_pkg::sqc_quad_t f_data;
    logic               b_valid, b_ready;
    sqc_pkg::sqc_quad_t b_data;

    sqc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_data  (f_data)
    );

    sqc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    sqc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_data  (b_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/sqc_checker.sv -----
// Port-level checks for sprite_quad_corners, attached by the bind below.
// Depends on sqc_pkg for the output word type.
`timescale 1ns / 1ps

module sqc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sqc_pkg::sqc_out_t m_data
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // Nothing is shown right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // The last mark sits on the fourth corner only.
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_corner == (m_data.corner_index == 2'd3)))
        else $error("last mark on wrong corner");

    // Corners of one sprite follow in order.
    a_corner_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_data.corner_index != 2'd3) |=>
        !m_valid || (m_data.corner_index == 2'($past(m_data.corner_index) + 2'd1)))
        else $error("corner out of order");

    // A waiting input word stays offered until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid dropped before acceptance");

endmodule

bind sprite_quad_corners sqc_checker u_sqc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
